// ===== sv/ibrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibrf_pkg: shared types and constants for the bridged IPMB request framer
// Holds the queue entry format, item kinds and the byte position codes
// used by the front end, the queue and the byte sequencer.
// ----------------------------------------------------------------------------
package ibrf_pkg;

   // item kind carried on req_tuser
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   // fixed header values
   localparam logic [7:0] SRC_ADDR     = 8'h20;
   localparam logic [7:0] LAN_TRACK    = 8'h40;
   localparam logic [1:0] SRC_LUN_IPMB = 2'b10;
   localparam logic [1:0] SRC_LUN_LAN  = 2'b00;
   localparam logic [5:0] SEQ_LAST     = 6'd62;

   // byte positions within one queue entry
   localparam logic [2:0] POS_CHANNEL = 3'd0;
   localparam logic [2:0] POS_TADDR   = 3'd1;
   localparam logic [2:0] POS_NETFN   = 3'd2;
   localparam logic [2:0] POS_HCHK    = 3'd3;
   localparam logic [2:0] POS_SRC     = 3'd4;
   localparam logic [2:0] POS_SEQ     = 3'd5;
   localparam logic [2:0] POS_CMD     = 3'd6;
   localparam logic [2:0] POS_TAIL    = 3'd7;
   localparam logic [2:0] POS_DATA      = 3'd0;
   localparam logic [2:0] POS_DATA_TAIL = 3'd1;

   // one unit of work for the byte sequencer
   typedef struct packed {
      logic       is_start;   // header burst, else a payload byte
      logic       last;       // trailing checksum follows
      logic [7:0] first;      // channel byte or payload byte
      logic [7:0] taddr;
      logic [7:0] netfn_lun;
      logic [7:0] hdr_chk;
      logic [7:0] seq_byte;
      logic [7:0] cmd;
      logic [7:0] tail_chk;   // negated running sum after this entry
   } entry_type;

endpackage

// ===== sv/ibrf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibrf_front: input classifier and frame state
// Accepts request items, tracks the sequence number, running sum and
// open-frame flag, and pushes one entry per producing item into the queue.
// ----------------------------------------------------------------------------
module ibrf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    func,
   input  logic [3:0]              channel,
   input  logic                    lan_mode,
   input  logic [5:0]              net_function,
   input  logic [7:0]              command,
   input  logic [7:0]              target_addr,
   input  logic [1:0]              target_lun,
   input  logic [7:0]              data_byte,
   input  logic                    last,
   input  logic                    q_full,
   output logic                    q_push,
   output ibrf_pkg::entry_type     q_entry
);

   logic [5:0] seq_ff, seq_in;
   logic [7:0] sum_ff, sum_in;
   logic       in_frame_ff, in_frame_in;

   logic       accept;
   logic       is_start;
   logic [5:0] seq_next;
   logic [7:0] netfn_lun;
   logic [7:0] addr_sum;
   logic [7:0] seq_byte;
   logic [7:0] start_sum;
   logic [7:0] data_sum;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_start  = (func == ibrf_pkg::FUNC_START);

   // header field arithmetic
   assign seq_next  = (seq_ff >= ibrf_pkg::SEQ_LAST) ? 6'd0 : seq_ff + 6'd1;
   assign netfn_lun = {net_function, target_lun};
   assign addr_sum  = target_addr + netfn_lun;
   assign seq_byte  = {seq_next,
                       lan_mode ? ibrf_pkg::SRC_LUN_LAN : ibrf_pkg::SRC_LUN_IPMB};
   assign start_sum = ibrf_pkg::SRC_ADDR + seq_byte + command;
   assign data_sum  = sum_ff + data_byte;

   // data outside a frame is dropped
   assign q_push = accept && (is_start || in_frame_ff);

   always_comb begin
      q_entry.is_start  = is_start;
      q_entry.last      = last;
      q_entry.first     = is_start ? ((lan_mode ? ibrf_pkg::LAN_TRACK : 8'h00) |
                                      {4'h0, channel})
                                   : data_byte;
      q_entry.taddr     = target_addr;
      q_entry.netfn_lun = netfn_lun;
      q_entry.hdr_chk   = 8'h00 - addr_sum;
      q_entry.seq_byte  = seq_byte;
      q_entry.cmd       = command;
      q_entry.tail_chk  = 8'h00 - (is_start ? start_sum : data_sum);
   end

   // frame state next values
   always_comb begin
      seq_in      = seq_ff;
      sum_in      = sum_ff;
      in_frame_in = in_frame_ff;
      if (q_push) begin
         if (is_start) begin
            seq_in = seq_next;
            sum_in = start_sum;
         end else begin
            sum_in = data_sum;
         end
         in_frame_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= ibrf_pkg::SEQ_LAST;
         sum_ff      <= 8'h00;
         in_frame_ff <= 1'b0;
      end else begin
         seq_ff      <= seq_in;
         sum_ff      <= sum_in;
         in_frame_ff <= in_frame_in;
      end
   end

   // sequence number stays below the modulus
   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      seq_ff <= ibrf_pkg::SEQ_LAST)
      else $error("sequence number out of range");

   // a start always opens a frame unless it closes at once
   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (q_push && is_start && !last) |=> in_frame_ff)
      else $error("start did not open frame");

   // a closing item leaves no frame open
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (q_push && last) |=> !in_frame_ff)
      else $error("frame left open after last");

endmodule

// ===== sv/ibrf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibrf_queue: entry queue between front end and sequencer
// Small circular buffer of work entries; the head is read in place.
// ----------------------------------------------------------------------------
module ibrf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ibrf_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output ibrf_pkg::entry_type  head_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [PW-1:0] PTR_ONE  = PW'(1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   ibrf_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count out of range");

endmodule

// ===== sv/ibrf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibrf_back: byte sequencer with output register
// Walks the head entry byte by byte into a registered result stage and
// pops the entry with its final byte.
// ----------------------------------------------------------------------------
module ibrf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  ibrf_pkg::entry_type  head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           frame_byte,
   output logic                 end_of_frame
);

   logic [2:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       eof_ff;

   logic       load;
   logic       tail;
   logic       done;
   logic [7:0] sel_byte;

   assign load = head_valid && (!valid_ff || rsp_ready);

   // byte select for the current position
   always_comb begin
      sel_byte = head_entry.tail_chk;
      tail     = 1'b0;
      done     = 1'b0;
      if (head_entry.is_start) begin
         unique case (pos_ff)
            ibrf_pkg::POS_CHANNEL: sel_byte = head_entry.first;
            ibrf_pkg::POS_TADDR:   sel_byte = head_entry.taddr;
            ibrf_pkg::POS_NETFN:   sel_byte = head_entry.netfn_lun;
            ibrf_pkg::POS_HCHK:    sel_byte = head_entry.hdr_chk;
            ibrf_pkg::POS_SRC:     sel_byte = ibrf_pkg::SRC_ADDR;
            ibrf_pkg::POS_SEQ:     sel_byte = head_entry.seq_byte;
            ibrf_pkg::POS_CMD: begin
               sel_byte = head_entry.cmd;
               done     = !head_entry.last;
            end
            default: begin
               sel_byte = head_entry.tail_chk;
               tail     = 1'b1;
               done     = 1'b1;
            end
         endcase
      end else begin
         if (pos_ff == ibrf_pkg::POS_DATA) begin
            sel_byte = head_entry.first;
            done     = !head_entry.last;
         end else begin
            tail = 1'b1;
            done = 1'b1;
         end
      end
   end

   assign pop = load && done;

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (load) begin
         pos_in   = done ? 3'd0 : pos_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= sel_byte;
         eof_ff  <= tail;
      end
   end

   assign rsp_valid    = valid_ff;
   assign frame_byte   = byte_ff;
   assign end_of_frame = eof_ff;

   // mid-entry position implies the entry is still queued
   a_pos_has_entry: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 3'd0) |-> head_valid)
      else $error("sequencer position without entry");

   // payload entries use at most two positions
   a_data_pos: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !head_entry.is_start) |-> (pos_ff <= ibrf_pkg::POS_DATA_TAIL))
      else $error("payload entry position out of range");

   // end marker only on a checksum pop
   a_eof_pops: assert property (@(posedge clock) disable iff (reset)
      (load && tail) |-> pop)
      else $error("trailing checksum did not retire entry");

endmodule

// ===== sv/ipmb_bridged_request_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmb_bridged_request_framer: bridged IPMB request payload builder
// Turns start and payload items into the byte stream of a bridged request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one item per transfer. req_tuser = 0 starts a frame with the
//   header fields, req_tuser = 1 carries one payload byte; req_tlast closes
//   the frame with a trailing checksum. Payload outside an open frame is
//   dropped. rsp_* delivers one frame byte per transfer, rsp_tlast on the
//   trailing checksum.
//   With the queue empty, an accepted item is first written into the queue,
//   then its first byte is loaded into the output register and presented.
//   The byte sequencer emits one byte per cycle while the receiver is ready;
//   a payload item yields one byte (two with the checksum) and a start item
//   seven (eight with the checksum). The front end keeps taking items every cycle
//   until the QUEUE_DEPTH-entry queue fills during a header burst.
//   Reset clears the queue, the output valid flag, the running sum and open
//   frame flag, and sets the sequence number so the first frame uses 0.
//   When the receiver stalls, the output byte holds, the sequencer waits and
//   the queue absorbs items until full, then req_tready drops.
// ----------------------------------------------------------------------------
module ipmb_bridged_request_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] channel, [4] lan_mode, [10:5] net_function, [18:11] command,
   // [26:19] target_addr, [28:27] target_lun, [36:29] data_byte, [39:37] zero
   input  logic [39:0] req_tdata,
   // [0] func
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   ibrf_pkg::entry_type push_entry;
   ibrf_pkg::entry_type head_entry;
   logic                q_push;
   logic                q_full;
   logic                q_head_valid;
   logic                q_pop;

   ibrf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .func         (req_tuser),
      .channel      (req_tdata[3:0]),
      .lan_mode     (req_tdata[4]),
      .net_function (req_tdata[10:5]),
      .command      (req_tdata[18:11]),
      .target_addr  (req_tdata[26:19]),
      .target_lun   (req_tdata[28:27]),
      .data_byte    (req_tdata[36:29]),
      .last         (req_tlast),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (push_entry)
   );

   ibrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (head_entry)
   );

   ibrf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (q_head_valid),
      .head_entry   (head_entry),
      .pop          (q_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .frame_byte   (rsp_tdata),
      .end_of_frame (rsp_tlast)
   );

endmodule

// ===== bench/tb_ipmb_bridged_request_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipmb_bridged_request_framer: self-checking bench for the request framer
// Drives start and payload transfers into the framer and keeps a local model
// of the sequence number, running sum and open-frame flag. The model queues
// each expected frame byte, and a monitor compares every output transfer
// against it. Directed cases, a sequence wrap pass, a long receiver hold and
// a random frame stream run in turn, with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_ipmb_bridged_request_framer;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 290;
   localparam int HOLD_CYCLES  = 300;

   // one input transfer, unpacked
   typedef struct {
      logic       func;
      logic [3:0] channel;
      logic       lan_mode;
      logic [5:0] net_function;
      logic [7:0] command;
      logic [7:0] target_addr;
      logic [1:0] target_lun;
      logic [7:0] data_byte;
      logic       last;
   } framer_req_type;

   // one expected output transfer
   typedef struct {
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   // model state
   logic [5:0]  seq_number = ibrf_pkg::SEQ_LAST;
   logic [7:0]  payload_sum = '0;
   logic        frame_open = 1'b0;
   frame_byte_type expected_frame_bytes[$];

   // idle control shared with the tests
   logic        sender_gaps = 1'b0;
   logic        receiver_gaps = 1'b0;
   int          hold_req_seq = 0;
   int          hold_ack_seq = 0;
   int          hold_len = 0;
   int          hold_left = 0;
   int          rx_wait = 0;

   // bookkeeping
   int          cycle_count = 0;
   int          fail_count = 0;
   int          starts_sent = 0;
   int          payload_sent = 0;
   int          dropped_sent = 0;
   int          bytes_checked = 0;
   int          tails_checked = 0;
   int          seq_wraps = 0;
   int          input_stalls = 0;

   ipmb_bridged_request_framer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected",
                  cycle_count, expected_frame_bytes.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stalls per transfer, plus a long hold on request
   always @(posedge clock) begin : receiver
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_ack_seq != hold_req_seq) begin
         hold_ack_seq <= hold_req_seq;
         hold_left    <= hold_len;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!receiver_gaps) begin
         rsp_tready <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         w = $urandom_range(0, 7);
         if (w == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rx_wait    <= w - 1;
         end
      end else if (!rsp_tready) begin
         if (rx_wait == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rx_wait <= rx_wait - 1;
         end
      end
   end

   // output monitor: compare each transfer with the oldest expected byte
   always @(posedge clock) begin : byte_checker
      frame_byte_type want;
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stalls++;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frame_bytes.size() == 0) begin
               $error("unexpected frame byte %02h (tlast %0b)", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_frame_bytes.pop_front();
               bytes_checked++;
               if (want.end_of_frame) tails_checked++;
               if (rsp_tdata !== want.frame_byte) begin
                  $error("frame_byte mismatch: expected %02h, actual %02h",
                         want.frame_byte, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.end_of_frame) begin
                  $error("end_of_frame mismatch: expected %0b, actual %0b",
                         want.end_of_frame, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   function automatic void expect_byte(input logic [7:0] b, input logic eof);
      frame_byte_type e;
      e.frame_byte   = b;
      e.end_of_frame = eof;
      expected_frame_bytes.push_back(e);
   endfunction

   // model of the framer: queue the bytes one accepted item produces
   function automatic void predict_frame_bytes(input framer_req_type it);
      logic [7:0] netfn_lun;
      logic [7:0] hdr_sum;
      logic [7:0] seq_byte;
      if (it.func == ibrf_pkg::FUNC_START) begin
         netfn_lun = {it.net_function, it.target_lun};
         hdr_sum   = it.target_addr + netfn_lun;
         if (seq_number == ibrf_pkg::SEQ_LAST) begin
            seq_number = '0;
            seq_wraps++;
         end else begin
            seq_number = seq_number + 6'd1;
         end
         seq_byte = {seq_number,
                     it.lan_mode ? ibrf_pkg::SRC_LUN_LAN : ibrf_pkg::SRC_LUN_IPMB};
         expect_byte((it.lan_mode ? ibrf_pkg::LAN_TRACK : 8'h00) | {4'h0, it.channel},
                     1'b0);
         expect_byte(it.target_addr, 1'b0);
         expect_byte(netfn_lun, 1'b0);
         expect_byte(8'h00 - hdr_sum, 1'b0);
         expect_byte(ibrf_pkg::SRC_ADDR, 1'b0);
         expect_byte(seq_byte, 1'b0);
         expect_byte(it.command, 1'b0);
         payload_sum = ibrf_pkg::SRC_ADDR + seq_byte + it.command;
         frame_open  = 1'b1;
         starts_sent++;
      end else if (!frame_open) begin
         // payload with no open frame is dropped
         dropped_sent++;
         return;
      end else begin
         expect_byte(it.data_byte, 1'b0);
         payload_sum = payload_sum + it.data_byte;
         payload_sent++;
      end
      if (it.last) begin
         expect_byte(8'h00 - payload_sum, 1'b1);
         frame_open = 1'b0;
      end
   endfunction

   function automatic framer_req_type random_req(input logic func, input logic last);
      framer_req_type it;
      it.func         = func;
      it.channel      = 4'($urandom);
      it.lan_mode     = 1'($urandom);
      it.net_function = 6'($urandom);
      it.command      = 8'($urandom);
      it.target_addr  = 8'($urandom);
      it.target_lun   = 2'($urandom);
      it.data_byte    = 8'($urandom);
      it.last         = last;
      return it;
   endfunction

   // drive one item and wait for its transfer; tvalid stays high afterward
   // so a following call in the same step keeps streaming
   task automatic send_item(input framer_req_type it);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tlast  <= it.last;
      req_tdata  <= {3'b000, it.data_byte, it.target_lun, it.target_addr, it.command,
                     it.net_function, it.lan_mode, it.channel};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frame_bytes(it);
   endtask

   // stop offering and wait until every expected byte has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_frame_bytes.size() != 0);
   endtask

   // field extremes, dropped payload, immediate close, abandoned frame
   task automatic test_directed_cases();
      framer_req_type it;
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      // payload before any frame is dropped
      it = random_req(ibrf_pkg::FUNC_DATA, 1'b0);
      it.data_byte = 8'hA5;
      send_item(it);
      send_item(random_req(ibrf_pkg::FUNC_DATA, 1'b1));
      // all-zero header; the payload byte on a start is ignored
      it = random_req(ibrf_pkg::FUNC_START, 1'b0);
      it.channel      = '0;
      it.lan_mode     = 1'b0;
      it.net_function = '0;
      it.command      = '0;
      it.target_addr  = '0;
      it.target_lun   = '0;
      it.data_byte    = 8'hFF;
      send_item(it);
      // payload extremes; header fields on data are ignored
      it = random_req(ibrf_pkg::FUNC_DATA, 1'b0);
      it.data_byte = 8'h00;
      send_item(it);
      it = random_req(ibrf_pkg::FUNC_DATA, 1'b0);
      it.data_byte = 8'hFF;
      send_item(it);
      it = random_req(ibrf_pkg::FUNC_DATA, 1'b1);
      it.data_byte = 8'h80;
      send_item(it);
      // all-ones header closed at once: eight bytes
      it = random_req(ibrf_pkg::FUNC_START, 1'b1);
      it.channel      = '1;
      it.lan_mode     = 1'b1;
      it.net_function = '1;
      it.command      = '1;
      it.target_addr  = '1;
      it.target_lun   = '1;
      it.data_byte    = 8'h00;
      send_item(it);
      // closed frame: payload dropped again
      it = random_req(ibrf_pkg::FUNC_DATA, 1'b1);
      it.data_byte = 8'h5A;
      send_item(it);
      // open LAN frame abandoned by a new non-LAN start
      it = random_req(ibrf_pkg::FUNC_START, 1'b0);
      it.lan_mode = 1'b1;
      send_item(it);
      it = random_req(ibrf_pkg::FUNC_DATA, 1'b0);
      it.data_byte = 8'h12;
      send_item(it);
      it = random_req(ibrf_pkg::FUNC_START, 1'b0);
      it.lan_mode = 1'b0;
      send_item(it);
      send_item(random_req(ibrf_pkg::FUNC_DATA, 1'b0));
      send_item(random_req(ibrf_pkg::FUNC_DATA, 1'b1));
      // a few with idling on both sides
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      send_item(random_req(ibrf_pkg::FUNC_START, 1'b0));
      send_item(random_req(ibrf_pkg::FUNC_DATA, 1'b0));
      send_item(random_req(ibrf_pkg::FUNC_DATA, 1'b1));
      send_item(random_req(ibrf_pkg::FUNC_START, 1'b1));
      wait_drained();
   endtask

   // enough frames to carry the sequence number past its top value
   task automatic test_sequence_wrap();
      repeat (66) begin
         sender_gaps   = ($urandom_range(0, 1) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         send_item(random_req(ibrf_pkg::FUNC_START, 1'($urandom)));
      end
      wait_drained();
   endtask

   // receiver holds off while the sender streams starts, filling the queue
   task automatic test_receiver_hold();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b1;
      hold_len      = HOLD_CYCLES;
      hold_req_seq++;
      repeat (8) send_item(random_req(ibrf_pkg::FUNC_START, 1'($urandom)));
      send_item(random_req(ibrf_pkg::FUNC_START, 1'b0));
      send_item(random_req(ibrf_pkg::FUNC_DATA, 1'b0));
      send_item(random_req(ibrf_pkg::FUNC_DATA, 1'b1));
      wait_drained();
   endtask

   // mostly well-formed frames with random content, some noise and broken frames
   task automatic test_random_frames();
      int first_count;
      int kind;
      int n;
      first_count = starts_sent + payload_sent;
      while (starts_sent + payload_sent - first_count < RANDOM_ITEMS) begin
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            // loose payload: dropped or landing in a frame left open
            repeat ($urandom_range(1, 3)) begin
               send_item(random_req(ibrf_pkg::FUNC_DATA, 1'($urandom)));
            end
         end else if (kind < 15) begin
            // frame left open, to be abandoned by the next start
            send_item(random_req(ibrf_pkg::FUNC_START, 1'b0));
            repeat ($urandom_range(0, 4)) send_item(random_req(ibrf_pkg::FUNC_DATA, 1'b0));
         end else begin
            n = $urandom_range(0, 8);
            send_item(random_req(ibrf_pkg::FUNC_START, n == 0));
            for (int i = 1; i <= n; i++) begin
               send_item(random_req(ibrf_pkg::FUNC_DATA, i == n));
            end
         end
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_sequence_wrap();
      test_receiver_hold();
      test_random_frames();
      wait_drained();
      repeat (16) @(posedge clock);
      $display("covered %0d starts, %0d payload bytes, %0d dropped items, %0d seq wraps",
               starts_sent, payload_sent, dropped_sent, seq_wraps);
      $display("checked %0d frame bytes incl. %0d trailing checksums; %0d input stall cycles",
               bytes_checked, tails_checked, input_stalls);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
